// ----- sv/cfilt_pkg.sv -----
// Shared types and constants for the three-axis complementary filter.
// Used by the multiplier, the constant divider and the core; no dependencies.
package cfilt_pkg;

	localparam int NUM_AXES = 3;
	localparam int AXIS_W = 2;
	localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

	// gain k, unsigned Q8.8, 10.0 after reset
	localparam logic [15:0] GAIN_RESET = 16'd2560;

	// shared multiplier: 48 x 16 unsigned
	localparam int MUL_A_W = 48;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// divide by microseconds per second, radix 4, two dividend bits per step
	localparam int DIV_N_W = 64;
	localparam int DIV_R_W = 20;
	localparam int DIV_STEPS = DIV_N_W / 2;
	localparam int DIV_CNT_W = 5;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);
	localparam logic [DIV_R_W+1:0] US_PER_S_X1 = 22'd1000000;
	localparam logic [DIV_R_W+1:0] US_PER_S_X2 = 22'd2000000;
	localparam logic [DIV_R_W+1:0] US_PER_S_X3 = 22'd3000000;

	// quotients never exceed 2^64 / 10^6, which fits in 45 bits
	localparam int QUOT_W = 45;
	localparam int SUM_W = 48;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_KK,
		ST_KK_WR,
		ST_ERR,
		ST_MLO,
		ST_MHI,
		ST_PSUM,
		ST_MP,
		ST_LOAD1,
		ST_DIV1,
		ST_INTEG,
		ST_X2,
		ST_M2,
		ST_LOAD2,
		ST_DIV2,
		ST_ANGLE,
		ST_DONE
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [31:0] r;
		if (v > 48'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -48'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- sv/cfilt_mul.sv -----
// Shared unsigned multiplier with a registered product.
// Depends on cfilt_pkg for operand widths.
module cfilt_mul (
	input  logic                          clk,
	input  logic                          en,
	input  logic [cfilt_pkg::MUL_A_W-1:0] a,
	input  logic [cfilt_pkg::MUL_B_W-1:0] b,
	output logic [cfilt_pkg::MUL_P_W-1:0] prod_q
);
	import cfilt_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= MUL_P_W'(a) * MUL_P_W'(b);
		end
	end

endmodule

// ----- sv/cfilt_div.sv -----
// Iterative divider by one million, two quotient bits per cycle.
// Depends on cfilt_pkg for the divisor multiples and step count.
module cfilt_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cfilt_pkg::DIV_N_W-1:0] dividend,
	output logic                          busy,
	output logic [cfilt_pkg::DIV_N_W-1:0] quotient
);
	import cfilt_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_R_W-1:0]   rem_q;
	logic [DIV_N_W-1:0]   n_q;
	logic [DIV_R_W+1:0]   rp;
	logic [DIV_R_W+1:0]   rnext;
	logic [1:0]           qd;

	// partial remainder with the next two dividend bits shifted in
	always_comb begin
		rp = {rem_q, n_q[DIV_N_W-1 -: 2]};
		if (rp >= US_PER_S_X3) begin
			qd = 2'd3;
			rnext = rp - US_PER_S_X3;
		end else if (rp >= US_PER_S_X2) begin
			qd = 2'd2;
			rnext = rp - US_PER_S_X2;
		end else if (rp >= US_PER_S_X1) begin
			qd = 2'd1;
			rnext = rp - US_PER_S_X1;
		end else begin
			qd = 2'd0;
			rnext = rp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	// quotient digits shift in at the low end as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			n_q   <= {n_q[DIV_N_W-3:0], qd};
			rem_q <= rnext[DIV_R_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = n_q;

endmodule

// ----- sv/three_axis_complementary_filter_core.sv -----
// Second-order complementary filter for roll, pitch and yaw. An item is
// accepted and k*k is formed; then each axis in turn takes two passes
// through the radix-4 divider by one million; then the result is handed
// off, after any wait for the previous result to be taken. The axes go one
// after the other through one shared 48x16 multiplier. in_stall is high
// while an item is in work; a finished result sits in the output register,
// so the next item can enter while it waits. Gain is written through
// cfg_we/cfg_wdata (Q8.8, 10.0 after reset) and must only change while the
// block is idle. Integrators and angles saturate at the signed 32-bit limits.
module three_axis_complementary_filter_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] roll_ref_angle,
	input  logic signed [31:0] pitch_ref_angle,
	input  logic signed [31:0] yaw_ref_angle,
	input  logic signed [31:0] roll_rate,
	input  logic signed [31:0] pitch_rate,
	input  logic signed [31:0] yaw_rate,
	input  logic [15:0]        interval_us,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] roll_angle,
	output logic signed [31:0] pitch_angle,
	output logic signed [31:0] yaw_angle
);
	import cfilt_pkg::*;

	state_t state_q, state_d;

	logic [15:0]        gain_q;
	logic [AXIS_W-1:0]  axis_q;
	logic signed [31:0] integ_q [NUM_AXES];
	logic signed [31:0] angle_q [NUM_AXES];
	logic signed [31:0] ref_q   [NUM_AXES];
	logic signed [31:0] rate_q  [NUM_AXES];
	logic [15:0]        iv_q;
	logic [31:0]        kk_q;
	logic [32:0]        emag_q;
	logic               eneg_q;
	logic [32:0]        tmp_q;
	logic [47:0]        psum_q;
	logic [47:0]        x2mag_q;
	logic               x2neg_q;
	logic               out_valid_q;
	logic signed [31:0] roll_angle_q, pitch_angle_q, yaw_angle_q;

	logic               mul_en;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod_q;
	logic               div_start;
	logic               div_busy;
	logic [DIV_N_W-1:0] quot;

	logic signed [32:0]      err;
	logic signed [SUM_W-1:0] quot_s;
	logic signed [SUM_W-1:0] prop_s;
	logic signed [SUM_W-1:0] integ_sum;
	logic signed [SUM_W-1:0] x2;
	logic signed [SUM_W-1:0] angle_sum;
	logic                    out_free;

	cfilt_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	cfilt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.busy     (div_busy),
		.quotient (quot)
	);

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_KK;
			ST_KK:    state_d = ST_KK_WR;
			ST_KK_WR: state_d = ST_ERR;
			ST_ERR:   state_d = ST_MLO;
			ST_MLO:   state_d = ST_MHI;
			ST_MHI:   state_d = ST_PSUM;
			ST_PSUM:  state_d = ST_MP;
			ST_MP:    state_d = ST_LOAD1;
			ST_LOAD1: state_d = ST_DIV1;
			ST_DIV1:  if (!div_busy) state_d = ST_INTEG;
			ST_INTEG: state_d = ST_X2;
			ST_X2:    state_d = ST_M2;
			ST_M2:    state_d = ST_LOAD2;
			ST_LOAD2: state_d = ST_DIV2;
			ST_DIV2:  if (!div_busy) state_d = ST_ANGLE;
			ST_ANGLE: state_d = (axis_q == LAST_AXIS) ? ST_DONE : ST_ERR;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// multiplier operand select and divider start
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		case (state_q)
			ST_KK: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(gain_q);
				mul_b  = gain_q;
			end
			ST_MLO: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(emag_q);
				mul_b  = kk_q[15:0];
			end
			ST_MHI: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(emag_q);
				mul_b  = kk_q[31:16];
			end
			ST_MP: begin
				mul_en = 1'b1;
				mul_a  = psum_q;
				mul_b  = iv_q;
			end
			ST_LOAD1: begin
				// proportional term e*k computed while the divider runs
				div_start = 1'b1;
				mul_en    = 1'b1;
				mul_a     = MUL_A_W'(emag_q);
				mul_b     = gain_q;
			end
			ST_M2: begin
				mul_en = 1'b1;
				mul_a  = x2mag_q;
				mul_b  = iv_q;
			end
			ST_LOAD2: begin
				div_start = 1'b1;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// datapath arithmetic
	always_comb begin
		err    = $signed({ref_q[axis_q][31], ref_q[axis_q]})
			- $signed({angle_q[axis_q][31], angle_q[axis_q]});
		quot_s = $signed({3'b000, quot[QUOT_W-1:0]});
		// 2*k*e in Q16.16 is |e|*k >> 7
		prop_s = $signed({6'b0, prod_q[48:7]});
		integ_sum = SUM_W'(integ_q[axis_q]) + (eneg_q ? -quot_s : quot_s);
		x2 = SUM_W'(integ_q[axis_q]) + (eneg_q ? -prop_s : prop_s)
			+ SUM_W'(rate_q[axis_q]);
		angle_sum = SUM_W'(angle_q[axis_q]) + (x2neg_q ? -quot_s : quot_s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_we) begin
			gain_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= '0;
			for (int i = 0; i < NUM_AXES; i++) begin
				integ_q[i] <= '0;
				angle_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE:  axis_q <= '0;
				ST_INTEG: integ_q[axis_q] <= sat32(integ_sum);
				ST_ANGLE: begin
					angle_q[axis_q] <= sat32(angle_sum);
					axis_q <= axis_q + 1'b1;
				end
				default: axis_q <= axis_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ref_q[0]  <= roll_ref_angle;
					ref_q[1]  <= pitch_ref_angle;
					ref_q[2]  <= yaw_ref_angle;
					rate_q[0] <= roll_rate;
					rate_q[1] <= pitch_rate;
					rate_q[2] <= yaw_rate;
					iv_q      <= interval_us;
				end
			end
			ST_KK_WR: kk_q <= prod_q[31:0];
			ST_ERR: begin
				eneg_q <= err[32];
				emag_q <= err[32] ? 33'(-err) : 33'(err);
			end
			// floor(|e|*kk / 2^16) = |e|*kk_hi + floor(|e|*kk_lo / 2^16)
			ST_MHI:  tmp_q <= prod_q[48:16];
			ST_PSUM: psum_q <= prod_q[47:0] + 48'(tmp_q);
			ST_X2: begin
				x2neg_q <= x2[SUM_W-1];
				x2mag_q <= x2[SUM_W-1] ? 48'(-x2) : 48'(x2);
			end
			ST_DONE: begin
				if (out_free) begin
					roll_angle_q  <= angle_q[0];
					pitch_angle_q <= angle_q[1];
					yaw_angle_q   <= angle_q[2];
				end
			end
			default: kk_q <= kk_q;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign roll_angle  = roll_angle_q;
	assign pitch_angle = pitch_angle_q;
	assign yaw_angle   = yaw_angle_q;

endmodule

// ----- tb/three_axis_complementary_filter_checker.sv -----
`timescale 1ns / 100ps
// Watches both channels and the gain port of the complementary filter core,
// predicts each item's three angles and compares them with the results.
// Depends on cfilt_pkg for the reset gain.
module three_axis_complementary_filter_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] roll_ref_angle,
	input  logic signed [31:0] pitch_ref_angle,
	input  logic signed [31:0] yaw_ref_angle,
	input  logic signed [31:0] roll_rate,
	input  logic signed [31:0] pitch_rate,
	input  logic signed [31:0] yaw_rate,
	input  logic [15:0]        interval_us,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] roll_angle,
	input  logic signed [31:0] pitch_angle,
	input  logic signed [31:0] yaw_angle,
	output int                 fail_count,
	output int                 pending
);

	localparam logic [63:0] MICROS_PER_S = 64'd1000000;

	typedef struct packed {
		logic signed [31:0] integ;
		logic signed [31:0] angle;
	} axis_t;

	typedef struct packed {
		logic signed [31:0] roll;
		logic signed [31:0] pitch;
		logic signed [31:0] yaw;
	} angles_t;

	axis_t       roll_st;
	axis_t       pitch_st;
	axis_t       yaw_st;
	logic [15:0] gain = cfilt_pkg::GAIN_RESET;
	angles_t     expected_angles_q[$];
	angles_t     want;

	function automatic logic signed [31:0] clamp_s32(input longint v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// one axis: integrator first, then the angle using the new integrator
	function automatic axis_t filter_axis_step(input axis_t st,
			input logic signed [31:0] ref_ang, input logic signed [31:0] rate_dps,
			input logic [15:0] dt_us, input logic [15:0] k);
		longint      err;
		longint      x2;
		logic        err_neg;
		logic [63:0] err_mag;
		logic [63:0] k64;
		logic [63:0] dt64;
		logic [63:0] integ_step;
		logic [63:0] prop_mag;
		logic [63:0] x2_mag;
		logic [63:0] angle_step;
		axis_t       nxt;
		k64 = {48'd0, k};
		dt64 = {48'd0, dt_us};
		err = longint'(ref_ang) - longint'(st.angle);
		err_neg = err < 0;
		err_mag = err_neg ? -err : err;
		integ_step = ((err_mag * (k64 * k64)) >> 16) * dt64 / MICROS_PER_S;
		nxt.integ = clamp_s32(longint'(st.integ) +
			(err_neg ? -longint'(integ_step) : longint'(integ_step)));
		// 2*k*e in Q16.16: k is Q8.8, so shift by 7
		prop_mag = (err_mag * k64) >> 7;
		x2 = longint'(nxt.integ) + (err_neg ? -longint'(prop_mag) : longint'(prop_mag)) +
			longint'(rate_dps);
		x2_mag = (x2 < 0) ? -x2 : x2;
		angle_step = x2_mag * dt64 / MICROS_PER_S;
		nxt.angle = clamp_s32(longint'(st.angle) +
			((x2 < 0) ? -longint'(angle_step) : longint'(angle_step)));
		return nxt;
	endfunction

	task automatic check_angle(input string name, input logic signed [31:0] exp_v,
			input logic signed [31:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_st = '0;
			pitch_st = '0;
			yaw_st = '0;
			gain = cfilt_pkg::GAIN_RESET;
			expected_angles_q.delete();
			pending = 0;
		end else begin
			// results first: a result taken at this edge belongs to an earlier item
			if (out_valid && !out_stall) begin
				if (expected_angles_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0d %0d %0d",
						$time, roll_angle, pitch_angle, yaw_angle);
					fail_count++;
				end else begin
					want = expected_angles_q.pop_front();
					check_angle("roll_angle", want.roll, roll_angle);
					check_angle("pitch_angle", want.pitch, pitch_angle);
					check_angle("yaw_angle", want.yaw, yaw_angle);
				end
			end
			if (in_valid && !in_stall) begin
				roll_st = filter_axis_step(roll_st, roll_ref_angle, roll_rate, interval_us, gain);
				pitch_st = filter_axis_step(pitch_st, pitch_ref_angle, pitch_rate, interval_us,
					gain);
				yaw_st = filter_axis_step(yaw_st, yaw_ref_angle, yaw_rate, interval_us, gain);
				expected_angles_q.push_back({roll_st.angle, pitch_st.angle, yaw_st.angle});
			end
			if (cfg_we) begin
				gain = cfg_wdata;
			end
			pending = expected_angles_q.size();
		end
	end

endmodule

// ----- tb/three_axis_complementary_filter_core_tb.sv -----
`timescale 1ns / 100ps
// Stimulus and verdict for the three-axis complementary filter core: directed
// and random IMU updates over several gains and idle patterns.
// Depends on cfilt_pkg, the core and three_axis_complementary_filter_checker.
module three_axis_complementary_filter_core_tb;

	localparam int QUIET_LIMIT = 5000;
	localparam int ITEMS_PER_PHASE = 205;
	localparam int NUM_PHASES = 8;
	localparam int ONE_DEG = 65536;
	localparam int REF_SPAN = 180 * ONE_DEG;
	localparam int RATE_SPAN = 2000 * ONE_DEG;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [31:0] roll_ref;
		logic signed [31:0] pitch_ref;
		logic signed [31:0] yaw_ref;
		logic signed [31:0] roll_dps;
		logic signed [31:0] pitch_dps;
		logic signed [31:0] yaw_dps;
		logic [15:0]        dt_us;
	} imu_update_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [15:0]        cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] roll_ref_angle;
	logic signed [31:0] pitch_ref_angle;
	logic signed [31:0] yaw_ref_angle;
	logic signed [31:0] roll_rate;
	logic signed [31:0] pitch_rate;
	logic signed [31:0] yaw_rate;
	logic [15:0]        interval_us;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] roll_angle;
	logic signed [31:0] pitch_angle;
	logic signed [31:0] yaw_angle;

	int fail_count;
	int pending_results;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles;

	three_axis_complementary_filter_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.roll_ref_angle  (roll_ref_angle),
		.pitch_ref_angle (pitch_ref_angle),
		.yaw_ref_angle   (yaw_ref_angle),
		.roll_rate       (roll_rate),
		.pitch_rate      (pitch_rate),
		.yaw_rate        (yaw_rate),
		.interval_us     (interval_us),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.roll_angle      (roll_angle),
		.pitch_angle     (pitch_angle),
		.yaw_angle       (yaw_angle)
	);

	three_axis_complementary_filter_checker u_angle_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.roll_ref_angle  (roll_ref_angle),
		.pitch_ref_angle (pitch_ref_angle),
		.yaw_ref_angle   (yaw_ref_angle),
		.roll_rate       (roll_rate),
		.pitch_rate      (pitch_rate),
		.yaw_rate        (yaw_rate),
		.interval_us     (interval_us),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.roll_angle      (roll_angle),
		.pitch_angle     (pitch_angle),
		.yaw_angle       (yaw_angle),
		.fail_count      (fail_count),
		.pending         (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// mostly plausible attitude values, some full-range, some at the limits
	function automatic logic signed [31:0] pick_q16(input int span);
		int                 sel;
		logic signed [31:0] r;
		sel = $urandom_range(99);
		if (sel < 55) begin
			r = int'($urandom_range(2 * span)) - span;
		end else if (sel < 85) begin
			r = $urandom;
		end else begin
			case ($urandom_range(4))
				0: r = S32_MAX;
				1: r = S32_MIN;
				2: r = 0;
				3: r = 1;
				default: r = -1;
			endcase
		end
		return r;
	endfunction

	function automatic logic [15:0] pick_interval();
		int          sel;
		logic [15:0] r;
		sel = $urandom_range(99);
		if (sel < 60) begin
			r = 16'($urandom_range(500, 20000));
		end else if (sel < 85) begin
			r = 16'($urandom_range(65535));
		end else begin
			case ($urandom_range(2))
				0: r = 16'd0;
				1: r = 16'd1;
				default: r = 16'hFFFF;
			endcase
		end
		return r;
	endfunction

	function automatic imu_update_t make_update(input logic signed [31:0] r_ref,
			input logic signed [31:0] p_ref, input logic signed [31:0] y_ref,
			input logic signed [31:0] r_dps, input logic signed [31:0] p_dps,
			input logic signed [31:0] y_dps, input logic [15:0] dt);
		imu_update_t u;
		u = '{r_ref, p_ref, y_ref, r_dps, p_dps, y_dps, dt};
		return u;
	endfunction

	function automatic imu_update_t random_update();
		imu_update_t u;
		u.roll_ref = pick_q16(REF_SPAN);
		u.pitch_ref = pick_q16(REF_SPAN);
		u.yaw_ref = pick_q16(REF_SPAN);
		u.roll_dps = pick_q16(RATE_SPAN);
		u.pitch_dps = pick_q16(RATE_SPAN);
		u.yaw_dps = pick_q16(RATE_SPAN);
		u.dt_us = pick_interval();
		return u;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, so the caller presents the next item or drops it
	task automatic send_update(input imu_update_t u);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		roll_ref_angle = u.roll_ref;
		pitch_ref_angle = u.pitch_ref;
		yaw_ref_angle = u.yaw_ref;
		roll_rate = u.roll_dps;
		pitch_rate = u.pitch_dps;
		yaw_rate = u.yaw_dps;
		interval_us = u.dt_us;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// gain may only change with the core idle: drain, then let it settle
	task automatic write_gain(input logic [15:0] g);
		in_valid = 1'b0;
		wait (pending_results == 0);
		repeat (240) @(negedge clk);
		cfg_wdata = g;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("three_axis_complementary_filter_core test failed");
		$finish;
	end

	initial begin
		logic [15:0] gain_sel;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = cfilt_pkg::GAIN_RESET;
		in_valid = 1'b0;
		roll_ref_angle = '0;
		pitch_ref_angle = '0;
		yaw_ref_angle = '0;
		roll_rate = '0;
		pitch_rate = '0;
		yaw_rate = '0;
		interval_us = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed items at the reset gain
		send_update(make_update(0, 0, 0, 0, 0, 0, 16'd0));
		send_update(make_update(10 * ONE_DEG, -10 * ONE_DEG, 90 * ONE_DEG, 0, 0, 0,
			16'd10000));
		// zero interval: nothing moves whatever the inputs
		send_update(make_update(S32_MAX, S32_MIN, 45 * ONE_DEG, S32_MAX, S32_MIN, 1,
			16'd0));
		// drive everything to the positive rail, then the negative one
		repeat (3) send_update(make_update(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX,
			S32_MAX, 16'hFFFF));
		repeat (3) send_update(make_update(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN,
			S32_MIN, 16'hFFFF));
		send_update(make_update(S32_MAX, S32_MIN, 0, S32_MIN, S32_MAX, 0, 16'd1));
		repeat (2) send_update(make_update(0, 0, 0, 0, 0, 0, 16'hFFFF));
		send_update(make_update(-1, 1, -ONE_DEG, ONE_DEG, -1, 0, 16'd1000));
		send_update(make_update(S32_MIN, S32_MAX, S32_MAX, 0, 0, 0, 16'hFFFF));
		send_update(make_update(1, -1, 0, -ONE_DEG, ONE_DEG, 0, 16'd20000));

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: gain_sel = 16'd0;
				1: gain_sel = 16'hFFFF;
				2: gain_sel = 16'd1;
				3: gain_sel = 16'd256;
				4: gain_sel = cfilt_pkg::GAIN_RESET;
				6: gain_sel = 16'd128;
				default: gain_sel = 16'($urandom_range(65535));
			endcase
			write_gain(gain_sel);
			case (phase % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 71;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 71;
				end
				default: begin
					idle_pct = 35;
					stall_pct = 35;
				end
			endcase
			repeat (ITEMS_PER_PHASE) send_update(random_update());
		end
		in_valid = 1'b0;

		wait (pending_results == 0);
		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending_results == 0) begin
			$display("three_axis_complementary_filter_core test passed");
		end else begin
			$display("three_axis_complementary_filter_core test failed");
		end
		$finish;
	end

endmodule
